[rtl/core/gssc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gssc_pkg
// Shared constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package gssc_pkg;

    localparam int MAX_CELLS   = 4096;
    localparam int MAX_COLUMNS = 64;
    localparam int CELL_W      = $clog2(MAX_CELLS);        // cell address
    localparam int CNT_W       = CELL_W + 1;               // count, holds MAX_CELLS + 1
    localparam int COL_W       = $clog2(MAX_COLUMNS);      // column index
    localparam int COLS_W      = 7;                        // column_count register
    localparam int SYM_W       = 8;
    localparam int DIR_W       = 3;                        // direction 0..3, 4 = exhausted
    localparam int MCNT_W      = $clog2(CNT_W);
    localparam int STK_W       = CELL_W + COL_W + DIR_W;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_TOO_BIG = 2'd1;
    localparam logic [1:0] STAT_PARTIAL = 2'd2;

    localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;

    typedef struct packed {
        logic       load;       // store an input cell
        logic       mod_init;
        logic       mod_step;   // one bit of total mod columns
        logic       scan_init;
        logic       scan_rd;    // read marks of the scan start cell
        logic       scan_take;  // start a walk at the scan cell
        logic       scan_next;
        logic       step_skip;  // neighbor not usable, next direction
        logic       nb_issue;   // read neighbor symbol and mark
        logic       push;
        logic       pop_issue;
        logic       pop_top;
        logic       pop_par;
        logic       res_set;
        logic       res_cyc;
        logic [1:0] res_stat;
    } t_cmd;

    typedef struct packed {
        logic total_over;
        logic mod_last;
        logic rem_nz;
        logic scan_done;
        logic rd_vis;
        logic sym_eq;
        logic dir_end;
        logic sp_one;
        logic sp_ge2;
        logic nb_ok;
    } t_sts;

    function automatic logic [COLS_W-1:0] eff_cols(input logic [COLS_W-1:0] c);
        logic [COLS_W-1:0] r;
        r = c;
        if (c == '0) r = COLS_W'(1);
        else if (c > COLS_W'(MAX_COLUMNS)) r = COLS_W'(MAX_COLUMNS);
        return r;
    endfunction

endpackage

[rtl/core/gssc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gssc_ctrl
// Sequencer: load, length check, depth-first walk, result handoff.
// ----------------------------------------------------------------------------
module gssc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  gssc_pkg::t_sts i_sts,
    output gssc_pkg::t_cmd o_cmd
);
    import gssc_pkg::*;

    typedef enum logic [10:0] {
        S_LOAD = 11'b00000000001,
        S_LEN  = 11'b00000000010,
        S_MOD  = 11'b00000000100,
        S_REM  = 11'b00000001000,
        S_SRD  = 11'b00000010000,
        S_SCHK = 11'b00000100000,
        S_STEP = 11'b00001000000,
        S_CHK  = 11'b00010000000,
        S_POP1 = 11'b00100000000,
        S_POP2 = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOAD;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    if (i_in_last) n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (i_sts.total_over) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_stat = STAT_TOO_BIG;
                    n_state      = S_OUT;
                end else begin
                    cmd.mod_init = 1'b1;
                    n_state      = S_MOD;
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (i_sts.mod_last) n_state = S_REM;
            end
            S_REM: begin
                if (i_sts.rem_nz) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_stat = STAT_PARTIAL;
                    n_state      = S_OUT;
                end else begin
                    cmd.scan_init = 1'b1;
                    n_state       = S_SRD;
                end
            end
            S_SRD: begin
                if (i_sts.scan_done) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_stat = STAT_OK;
                    n_state      = S_OUT;
                end else begin
                    cmd.scan_rd = 1'b1;
                    n_state     = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_sts.rd_vis) begin
                    cmd.scan_next = 1'b1;
                    n_state       = S_SRD;
                end else begin
                    cmd.scan_take = 1'b1;
                    n_state       = S_STEP;
                end
            end
            S_STEP: begin
                priority if (i_sts.dir_end && i_sts.sp_one) begin
                    cmd.scan_next = 1'b1;
                    n_state       = S_SRD;
                end else if (i_sts.dir_end) begin
                    cmd.pop_issue = 1'b1;
                    n_state       = S_POP1;
                end else if (i_sts.nb_ok) begin
                    cmd.nb_issue = 1'b1;
                    n_state      = S_CHK;
                end else begin
                    cmd.step_skip = 1'b1;
                end
            end
            S_CHK: begin
                priority if (!i_sts.sym_eq) begin
                    n_state = S_STEP;
                end else if (i_sts.rd_vis) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_cyc  = 1'b1;
                    cmd.res_stat = STAT_OK;
                    n_state      = S_OUT;
                end else begin
                    cmd.push = 1'b1;
                    n_state  = S_STEP;
                end
            end
            S_POP1: begin
                cmd.pop_top = 1'b1;
                n_state     = i_sts.sp_ge2 ? S_POP2 : S_STEP;
            end
            S_POP2: begin
                cmd.pop_par = 1'b1;
                n_state     = S_STEP;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT);

endmodule

[rtl/core/gssc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gssc_dp
// Datapath: symbol, mark and walk stack memories, walk registers, result.
// ----------------------------------------------------------------------------
module gssc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [gssc_pkg::COLS_W-1:0]   i_cfg_wr_data,
    input  logic [gssc_pkg::SYM_W-1:0]    i_sym,
    input  logic                          i_last,
    input  gssc_pkg::t_cmd                i_cmd,
    output gssc_pkg::t_sts                o_sts,
    output logic                          o_has_cycle,
    output logic [1:0]                    o_status
);
    import gssc_pkg::*;

    logic [SYM_W-1:0] sym_mem [MAX_CELLS];
    logic             vis_mem [MAX_CELLS];
    logic [STK_W-1:0] stk_mem [MAX_CELLS];

    logic [COLS_W-1:0] r_cfg;
    logic [CNT_W-1:0]  r_cnt, n_cnt, r_total;
    logic [COL_W-1:0]  r_rem;
    logic [MCNT_W-1:0] r_mcnt;
    logic [CNT_W-1:0]  r_start;
    logic [COL_W-1:0]  r_start_col;
    logic [CELL_W-1:0] r_cur, r_par, r_nb;
    logic [COL_W-1:0]  r_col, r_ncol;
    logic [DIR_W-1:0]  r_dir;
    logic [CNT_W-1:0]  r_sp;
    logic [SYM_W-1:0]  r_csym;
    logic [SYM_W-1:0]  r_sym_rd;
    logic              r_vis_rd;
    logic [STK_W-1:0]  r_stk_rd;
    logic              r_has_cycle;
    logic [1:0]        r_status;

    logic [COLS_W-1:0] cols, cols_m1;
    logic [COLS_W:0]   rem_sh;
    logic [CELL_W-1:0] rd_addr, vis_waddr, nb;
    logic              vis_we, vis_wd;
    logic [COL_W-1:0]  ncol;
    logic              nb_in;
    logic [CNT_W-1:0]  sp_m1, sp_m2;

    assign cols    = eff_cols(r_cfg);
    assign cols_m1 = cols - COLS_W'(1);
    assign n_cnt   = (r_cnt < CNT_W'(MAX_CELLS)) ? r_cnt + CNT_W'(1) : CNT_W'(MAX_CELLS + 1);
    assign sp_m1   = r_sp - CNT_W'(1);
    assign sp_m2   = r_sp - CNT_W'(2);
    assign rem_sh  = {1'b0, r_rem, r_total[r_mcnt]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= COLS_RESET;
            r_cnt <= '0;
        end else begin
            if (i_cfg_wr_en) r_cfg <= i_cfg_wr_data;
            if (i_cmd.load)  r_cnt <= i_last ? '0 : n_cnt;
        end
    end

    // neighbor address and bounds for the current direction
    always_comb begin
        nb    = r_cur;
        ncol  = r_col;
        nb_in = 1'b0;
        unique case (r_dir[1:0])
            DIR_RIGHT: begin
                nb    = r_cur + CELL_W'(1);
                ncol  = r_col + COL_W'(1);
                nb_in = ({1'b0, r_col} != cols_m1);
            end
            DIR_DOWN: begin
                nb    = r_cur + CELL_W'(cols);
                nb_in = ({1'b0, r_cur} + CNT_W'(cols)) < r_total;
            end
            DIR_UP: begin
                nb    = r_cur - CELL_W'(cols);
                nb_in = ({1'b0, r_cur} >= CNT_W'(cols));
            end
            DIR_LEFT: begin
                nb    = r_cur - CELL_W'(1);
                ncol  = r_col - COL_W'(1);
                nb_in = (r_col != '0);
            end
            default: ;
        endcase
    end

    assign rd_addr = i_cmd.scan_rd ? r_start[CELL_W-1:0] : nb;

    always_comb begin
        vis_we    = 1'b0;
        vis_wd    = 1'b0;
        vis_waddr = r_cnt[CELL_W-1:0];
        if (i_cmd.load && r_cnt < CNT_W'(MAX_CELLS)) begin
            vis_we = 1'b1;   // marks are cleared as the grid loads
        end else if (i_cmd.scan_take) begin
            vis_we    = 1'b1;
            vis_wd    = 1'b1;
            vis_waddr = r_start[CELL_W-1:0];
        end else if (i_cmd.push) begin
            vis_we    = 1'b1;
            vis_wd    = 1'b1;
            vis_waddr = r_nb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_cnt < CNT_W'(MAX_CELLS)) sym_mem[r_cnt[CELL_W-1:0]] <= i_sym;
        if (vis_we) vis_mem[vis_waddr] <= vis_wd;
        if (i_cmd.push) stk_mem[sp_m1[CELL_W-1:0]] <= {r_cur, r_col, r_dir};
        r_sym_rd <= sym_mem[rd_addr];
        r_vis_rd <= vis_mem[rd_addr];
        r_stk_rd <= stk_mem[sp_m2[CELL_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_last) r_total <= n_cnt;
        if (i_cmd.mod_init) begin
            r_rem  <= '0;
            r_mcnt <= MCNT_W'(CNT_W - 1);
        end
        if (i_cmd.mod_step) begin
            r_rem  <= (rem_sh >= {1'b0, cols}) ? COL_W'(rem_sh - {1'b0, cols})
                                                : COL_W'(rem_sh);
            r_mcnt <= r_mcnt - MCNT_W'(1);
        end
        if (i_cmd.scan_init) begin
            r_start     <= '0;
            r_start_col <= '0;
        end
        if (i_cmd.scan_next) begin
            r_start     <= r_start + CNT_W'(1);
            r_start_col <= ({1'b0, r_start_col} == cols_m1) ? '0 : r_start_col + COL_W'(1);
        end
        if (i_cmd.scan_take) begin
            r_cur  <= r_start[CELL_W-1:0];
            r_col  <= r_start_col;
            r_dir  <= '0;
            r_sp   <= CNT_W'(1);
            r_csym <= r_sym_rd;
        end
        if (i_cmd.step_skip) r_dir <= r_dir + DIR_W'(1);
        if (i_cmd.nb_issue) begin
            r_nb   <= nb;
            r_ncol <= ncol;
            r_dir  <= r_dir + DIR_W'(1);
        end
        if (i_cmd.push) begin
            r_par <= r_cur;
            r_cur <= r_nb;
            r_col <= r_ncol;
            r_dir <= '0;
            r_sp  <= r_sp + CNT_W'(1);
        end
        if (i_cmd.pop_issue) r_sp <= sp_m1;
        if (i_cmd.pop_top) {r_cur, r_col, r_dir} <= r_stk_rd;
        if (i_cmd.pop_par) r_par <= r_stk_rd[STK_W-1 -: CELL_W];
        if (i_cmd.res_set) begin
            r_has_cycle <= i_cmd.res_cyc;
            r_status    <= i_cmd.res_stat;
        end
    end

    assign o_sts.total_over = r_total > CNT_W'(MAX_CELLS);
    assign o_sts.mod_last   = (r_mcnt == '0);
    assign o_sts.rem_nz     = (r_rem != '0);
    assign o_sts.scan_done  = (r_start == r_total);
    assign o_sts.rd_vis     = r_vis_rd;
    assign o_sts.sym_eq     = (r_sym_rd == r_csym);
    assign o_sts.dir_end    = r_dir[DIR_W-1];
    assign o_sts.sp_one     = (r_sp == CNT_W'(1));
    assign o_sts.sp_ge2     = (r_sp >= CNT_W'(2));
    // the cell the walk came from is not a candidate
    assign o_sts.nb_ok      = nb_in && !(r_sp >= CNT_W'(2) && nb == r_par);

    assign o_has_cycle = r_has_cycle;
    assign o_status    = r_status;

endmodule

[rtl/core/grid_same_symbol_cycle_detect.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_same_symbol_cycle_detect
// Detects a cycle among equal-symbol cells joined up, down, left and right.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one cell per transfer in raster order: tdata is the 8-bit
//   symbol, tlast marks the final cell of the grid. The row length comes from
//   i_cfg_wr_data when i_cfg_wr_en is high (0 acts as 1, above 64 as 64).
//   Each grid gives one m_axis transfer: tdata[0] has_cycle, tdata[2:1]
//   status (0 ok, 1 more than 4096 cells, 2 partial last row).
// Timing:
//   cells load at one per cycle. After tlast the block checks the length,
//   then walks the grid depth first: each cell scanned, neighbor probe and
//   pop is a short sequence of states, bounded by the single read port of
//   the symbol/mark memories. s_axis_tready stays low from tlast until the
//   result transfer.
// Reset:
//   row length returns to 64 and the cell count to zero; no memory clearing
//   is needed since marks are cleared while cells load.
// Stall:
//   the result holds on m_axis until m_axis_tready; no input is taken meanwhile.
// ----------------------------------------------------------------------------
module grid_same_symbol_cycle_detect (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data,     // column_count
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,      // [7:0] cell_symbol
    input  logic       s_axis_tlast,      // last_cell
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata       // [0] has_cycle, [2:1] status, rest zero
);
    import gssc_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic       has_cycle;
    logic [1:0] status;

    gssc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gssc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sym         (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_has_cycle   (has_cycle),
        .o_status      (status)
    );

    assign m_axis_tdata = {5'b00000, status, has_cycle};

endmodule

[rtl/core/gssc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gssc_checker
// Port-level checks of the cycle detector, bound to the top level.
// ----------------------------------------------------------------------------
module gssc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    import gssc_pkg::*;

    // a held result keeps its value
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no cell is taken while a result is pending
    ap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready during result");

    ap_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:1] == STAT_OK || m_axis_tdata[2:1] == STAT_TOO_BIG
                           || m_axis_tdata[2:1] == STAT_PARTIAL))
        else $error("bad status code");

    // an error grid never claims a cycle
    ap_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:1] != STAT_OK |-> !m_axis_tdata[0])
        else $error("cycle flagged on error");

    ap_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");

endmodule

bind grid_same_symbol_cycle_detect gssc_checker u_gssc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Grid same-symbol cycle detector: a directed table of grids, then random grids.
// Each grid is loaded over s_axis, random ones under varied idle/stall patterns. A
// union-find predictor (or the table, for typed rows) gives has_cycle and status,
// and every m_axis transfer is checked against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;
    import gssc_pkg::*;

    typedef enum int {FILL_CONST, FILL_INDEX, FILL_TWO, FILL_THREE, FILL_RAND} t_fill;

    typedef struct {
        int          row_len;   // register value written before the grid, -1 keeps it
        int          n_cells;
        t_fill       fill;
        logic [7:0]  sym;
        bit          typed;
        logic        exp_cyc;
        logic [1:0]  exp_stat;
    } t_grid_row;

    typedef struct packed {
        logic       cyc;
        logic [1:0] stat;
    } t_verdict;

    logic       i_clk, i_rst_n;
    logic       i_cfg_wr_en;
    logic [6:0] i_cfg_wr_data;
    logic       s_axis_tvalid, s_axis_tready, s_axis_tlast;
    logic [7:0] s_axis_tdata;
    logic       m_axis_tvalid, m_axis_tready;
    logic [7:0] m_axis_tdata;

    grid_same_symbol_cycle_detect dut (.*);

    // predictor state
    logic [7:0]  grid_syms[$];
    int          grid_cells;
    logic [6:0]  row_len_reg;
    t_verdict    verdicts_due[$];
    int          uf_parent[MAX_CELLS];
    bit          typed_next;
    t_verdict    typed_verdict;

    int send_idle_pct, recv_stall_pct, hold_cycles, mismatches;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report(input string what);
        mismatches++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    function automatic int uf_root(input int c);
        int r;
        r = c;
        while (uf_parent[r] != r) r = uf_parent[r];
        uf_parent[c] = r;
        return r;
    endfunction

    // cycle iff two already-joined cells of equal symbol get joined again
    function automatic t_verdict grid_verdict();
        t_verdict v;
        int cols, rows, a, b;
        v = '{cyc: 1'b0, stat: STAT_OK};
        cols = (row_len_reg == 0) ? 1 : (row_len_reg > MAX_COLUMNS) ? MAX_COLUMNS
                                                                     : row_len_reg;
        if (grid_cells > MAX_CELLS) begin
            v.stat = STAT_TOO_BIG;
        end else if (grid_cells % cols != 0) begin
            v.stat = STAT_PARTIAL;
        end else begin
            rows = grid_cells / cols;
            for (int i = 0; i < grid_cells; i++) uf_parent[i] = i;
            for (int i = 0; i < grid_cells; i++) begin
                for (int d = 0; d < 2; d++) begin
                    if (d == 0 && (i % cols) == cols - 1) continue;
                    if (d == 1 && (i / cols) == rows - 1) continue;
                    b = (d == 0) ? i + 1 : i + cols;
                    if (grid_syms[i] != grid_syms[b]) continue;
                    a = uf_root(i);
                    b = uf_root(b);
                    if (a == b) v.cyc = 1'b1;
                    else uf_parent[a] = b;
                end
            end
        end
        return v;
    endfunction

    task automatic record_cell(input logic [7:0] sym, input logic last);
        if (grid_cells < MAX_CELLS) grid_syms.push_back(sym);
        if (grid_cells <= MAX_CELLS) grid_cells++;
        if (last) begin
            verdicts_due.push_back(typed_next ? typed_verdict : grid_verdict());
            typed_next = 1'b0;
            grid_syms.delete();
            grid_cells = 0;
        end
    endtask

    task automatic send_cell(input logic [7:0] sym, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        record_cell(sym, last);
    endtask

    task automatic send_grid(input int n, input t_fill fill, input logic [7:0] base);
        logic [7:0] sym;
        for (int i = 0; i < n; i++) begin
            case (fill)
                FILL_CONST: sym = base;
                FILL_INDEX: sym = base + 8'(i);
                FILL_TWO:   sym = base + 8'($urandom_range(1));
                FILL_THREE: sym = base + 8'($urandom_range(2));
                default:    sym = 8'($urandom);
            endcase
            send_cell(sym, i == n - 1);
        end
    endtask

    // only once every result is back, so the block is idle
    task automatic write_row_len(input logic [6:0] val);
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        row_len_reg = val;
    endtask

    // receiver and result check
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                report($sformatf("unexpected result 0x%02h", m_axis_tdata));
            end else begin
                t_verdict v;
                v = verdicts_due.pop_front();
                if (m_axis_tdata[0] !== v.cyc)
                    report($sformatf("has_cycle %b, want %b", m_axis_tdata[0], v.cyc));
                if (m_axis_tdata[2:1] !== v.stat)
                    report($sformatf("status %0d, want %0d", m_axis_tdata[2:1], v.stat));
                if (m_axis_tdata[7:3] !== 5'd0)
                    report($sformatf("padding bits 0x%02h", m_axis_tdata[7:3]));
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    t_grid_row plan[] = '{
        '{-1,   3,    FILL_CONST, 8'h11, 1, 1'b0, STAT_PARTIAL},
        '{1,    1,    FILL_CONST, 8'hFF, 1, 1'b0, STAT_OK},
        '{2,    4,    FILL_CONST, 8'h00, 1, 1'b1, STAT_OK},
        '{2,    4,    FILL_INDEX, 8'h00, 1, 1'b0, STAT_OK},
        '{0,    3,    FILL_CONST, 8'h80, 1, 1'b0, STAT_OK},
        '{127,  64,   FILL_CONST, 8'h55, 1, 1'b0, STAT_OK},
        '{-1,   128,  FILL_CONST, 8'hAA, 1, 1'b1, STAT_OK},
        '{3,    5,    FILL_CONST, 8'h01, 1, 1'b0, STAT_PARTIAL},
        '{3,    9,    FILL_TWO,   8'h7E, 0, 1'b0, STAT_OK},
        '{64,   4097, FILL_CONST, 8'h42, 1, 1'b0, STAT_TOO_BIG},
        '{-1,   4096, FILL_CONST, 8'h43, 1, 1'b1, STAT_OK},
        '{4,    12,   FILL_RAND,  8'h00, 0, 1'b0, STAT_OK}
    };

    initial begin
        int rows, cols, n, sent;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        mismatches = 0;
        grid_cells = 0;
        typed_next = 1'b0;
        row_len_reg = COLS_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].row_len >= 0) write_row_len(7'(plan[k].row_len));
            typed_next = plan[k].typed;
            typed_verdict = '{cyc: plan[k].exp_cyc, stat: plan[k].exp_stat};
            send_grid(plan[k].n_cells, plan[k].fill, plan[k].sym);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            // the long hold-off: result waits, input backs up behind it
            if (phase == 0) hold_cycles = 400;
            sent = 0;
            while (sent < 275) begin
                if ($urandom_range(3) == 0) begin
                    write_row_len(($urandom_range(9) == 0) ? 7'($urandom)
                                                           : 7'($urandom_range(1, 6)));
                end
                cols = (row_len_reg == 0) ? 1 : (row_len_reg > MAX_COLUMNS) ? MAX_COLUMNS
                                                                             : row_len_reg;
                rows = $urandom_range(1, (cols > 16) ? 2 : 6);
                n = rows * cols;
                if ($urandom_range(7) == 0) n = n + $urandom_range(1, 3) - 2;
                if (n < 1) n = 1;
                case ($urandom_range(9))
                    0: send_grid(n, FILL_RAND, 8'h00);
                    1: send_grid(n, FILL_CONST, 8'($urandom));
                    2, 3, 4: send_grid(n, FILL_THREE, 8'($urandom));
                    default: send_grid(n, FILL_TWO, 8'($urandom));
                endcase
                sent += n;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
